// ===== rtl/tpa_pkg.sv =====
// Package for the triangle plane and area pipeline: field widths, the internal
// word widths and the structs passed between the pipeline sections.
// No dependencies.
package tpa_pkg;

	localparam int CW     = 24;        // vertex coordinate, Q12.12
	localparam int EW     = CW + 1;    // edge vector component
	localparam int NW     = 2 * EW;    // cross product component, signed
	localparam int MW     = NW - 1;    // cross product magnitude
	localparam int LO_W   = 25;        // low slice of a magnitude for squaring
	localparam int HI_W   = MW - LO_W; // high slice
	localparam int SW     = 100;       // squared length of the cross product
	localparam int TW     = SW + 2;    // square root remainder and trial
	localparam int LW     = SW / 2;    // integer square root
	localparam int QW     = 23;        // quotient of one normal component
	localparam int NQ_W   = 24;        // unit normal component, Q2.22
	localparam int D_W    = 25;        // plane offset, Q13.12
	localparam int AREA_W = 37;        // area, Q25.12
	localparam int DOT_PW = 2 * CW;    // normal by vertex product
	localparam int DOT_W  = DOT_PW + 2;
	localparam int DM_W   = 27;        // rounded offset magnitude
	localparam int IN_W   = 9 * CW;
	localparam int OUT_W  = 136;       // 3 normals, offset, area, padded to bytes

	localparam logic [QW-1:0]   ONE_Q22  = QW'(4194304);
	localparam logic [DM_W-1:0] DM_LIMIT = DM_W'(67108864);
	localparam logic signed [D_W-1:0] D_MAX = 25'sh0FFFFFF;
	localparam logic signed [D_W-1:0] D_MIN = 25'sh1000000;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [MW-1:0]        mag_t;

	// side information that travels with a triangle through the long sections
	typedef struct packed {
		coord_t [2:0] a;
		logic   [2:0] neg;
		logic         degen;
	} tri_side_t;

	typedef struct packed {
		logic                     degen;
		logic [AREA_W-1:0]        area;
		logic signed [D_W-1:0]    offset;
		logic signed [NQ_W-1:0]   nz;
		logic signed [NQ_W-1:0]   ny;
		logic signed [NQ_W-1:0]   nx;
	} tpa_res_t;

endpackage

// ===== rtl/tpa_front.sv =====
// Front section: edge vectors, cross product, squared length.
// Six register stages; depends on tpa_pkg.
module tpa_front import tpa_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  coord_t [2:0]    a,
	input  coord_t [2:0]    b,
	input  coord_t [2:0]    c,
	output logic            out_valid,
	output logic [SW-1:0]   s,
	output mag_t [2:0]      m,
	output tri_side_t       side
);

	logic [6:1] vld_s;

	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	coord_t               a_s1  [3];
	logic signed [NW-1:0] p_s2  [6];
	coord_t               a_s2  [3];
	mag_t                 m_s3  [3];
	logic [2:0]           neg_s3;
	coord_t               a_s3  [3];
	logic [2*HI_W-1:0]    hh_s4 [3];
	logic [MW-1:0]        hl_s4 [3];
	logic [2*LO_W-1:0]    ll_s4 [3];
	mag_t                 m_s4  [3];
	logic [2:0]           neg_s4;
	coord_t               a_s4  [3];
	logic [SW-1:0]        sq_s5 [3];
	mag_t                 m_s5  [3];
	logic [2:0]           neg_s5;
	coord_t               a_s5  [3];
	logic [SW-1:0]        s_s6;
	mag_t [2:0]           m_s6;
	tri_side_t            side_s6;

	logic signed [NW-1:0] prod [6];
	logic signed [NW-1:0] n    [3];
	logic [SW-1:0]        ssum;

	always_comb begin
		prod[0] = e1_s1[1] * e2_s1[2];
		prod[1] = e1_s1[2] * e2_s1[1];
		prod[2] = e1_s1[2] * e2_s1[0];
		prod[3] = e1_s1[0] * e2_s1[2];
		prod[4] = e1_s1[0] * e2_s1[1];
		prod[5] = e1_s1[1] * e2_s1[0];
		for (int i = 0; i < 3; i++) begin
			n[i] = p_s2[2*i] - p_s2[2*i+1];
		end
		ssum = sq_s5[0] + sq_s5[1] + sq_s5[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[5:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EW'(b[i]) - EW'(a[i]);
				e2_s1[i] <= EW'(c[i]) - EW'(a[i]);
				a_s1[i]  <= a[i];
				a_s2[i]  <= a_s1[i];
				// magnitude of the cross product component
				m_s3[i]  <= MW'(n[i][NW-1] ? -n[i] : n[i]);
				neg_s3[i] <= n[i][NW-1];
				a_s3[i]  <= a_s2[i];
				hh_s4[i] <= m_s3[i][MW-1:LO_W] * m_s3[i][MW-1:LO_W];
				hl_s4[i] <= m_s3[i][MW-1:LO_W] * m_s3[i][LO_W-1:0];
				ll_s4[i] <= m_s3[i][LO_W-1:0] * m_s3[i][LO_W-1:0];
				m_s4[i]  <= m_s3[i];
				a_s4[i]  <= a_s3[i];
				sq_s5[i] <= (SW'(hh_s4[i]) << (2 * LO_W)) + (SW'(hl_s4[i]) << (LO_W + 1))
					+ SW'(ll_s4[i]);
				m_s5[i]  <= m_s4[i];
				a_s5[i]  <= a_s4[i];
				m_s6[i]  <= m_s5[i];
				side_s6.a[i] <= a_s5[i];
			end
			for (int i = 0; i < 6; i++) begin
				p_s2[i] <= prod[i];
			end
			neg_s4        <= neg_s3;
			neg_s5        <= neg_s4;
			side_s6.neg   <= neg_s5;
			side_s6.degen <= (ssum == '0);
			s_s6          <= ssum;
		end
	end

	assign out_valid = vld_s[6];
	assign s         = s_s6;
	assign m         = m_s6;
	assign side      = side_s6;

endmodule

// ===== rtl/tpa_sqrt.sv =====
// Integer square root, one result bit per register stage.
// LW stages; depends on tpa_pkg.
module tpa_sqrt import tpa_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [SW-1:0]   s,
	input  mag_t [2:0]      m,
	input  tri_side_t       side,
	output logic            out_valid,
	output logic [LW-1:0]   l,
	output mag_t [2:0]      m_out,
	output tri_side_t       side_out
);

	// index k holds the word after k stages; index 0 is the input
	logic            vld_sn  [LW+1];
	logic [TW-1:0]   rem_sn  [LW+1];
	logic [LW-1:0]   root_sn [LW+1];
	mag_t [2:0]      m_sn    [LW+1];
	tri_side_t       side_sn [LW+1];

	assign vld_sn[0]  = in_valid;
	assign rem_sn[0]  = TW'(s);
	assign root_sn[0] = '0;
	assign m_sn[0]    = m;
	assign side_sn[0] = side;

	for (genvar k = 0; k < LW; k++) begin : g_stage
		localparam int B = LW - 1 - k;
		logic [TW-1:0] trial;
		logic          take;

		// (r + 2^B)^2 - r^2
		always_comb begin
			trial = (TW'(root_sn[k]) << (B + 1)) + (TW'(1) << (2 * B));
			take  = (rem_sn[k] >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k+1] <= 1'b0;
			end else if (en) begin
				vld_sn[k+1] <= vld_sn[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sn[k+1]  <= take ? rem_sn[k] - trial : rem_sn[k];
				root_sn[k+1] <= take ? (root_sn[k] | (LW'(1) << B)) : root_sn[k];
				m_sn[k+1]    <= m_sn[k];
				side_sn[k+1] <= side_sn[k];
			end
		end
	end

	assign out_valid = vld_sn[LW];
	assign l         = root_sn[LW];
	assign m_out     = m_sn[LW];
	assign side_out  = side_sn[LW];

endmodule

// ===== rtl/tpa_div.sv =====
// Three restoring dividers side by side, one quotient bit per register stage,
// giving |N_i| * 2^22 / L with a round-up flag. QW stages; depends on tpa_pkg.
module tpa_div import tpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [LW-1:0]        l,
	input  mag_t [2:0]           m,
	input  tri_side_t            side,
	output logic                 out_valid,
	output logic [2:0][QW-1:0]   q,
	output logic [2:0]           rnd,
	output logic [LW-1:0]        l_out,
	output tri_side_t            side_out
);

	logic            vld_sn  [QW+1];
	logic [LW:0]     rem_sn  [QW+1][3];
	logic [QW-1:0]   q_sn    [QW+1][3];
	logic [LW-1:0]   l_sn    [QW+1];
	tri_side_t       side_sn [QW+1];

	assign vld_sn[0]  = in_valid;
	assign l_sn[0]    = l;
	assign side_sn[0] = side;
	for (genvar i = 0; i < 3; i++) begin : g_lane_in
		assign rem_sn[0][i] = (LW+1)'(m[i]);
		assign q_sn[0][i]   = '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [LW:0] cand [3];
		logic [2:0]  take;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				// the first step compares the magnitude as it stands
				cand[i] = (k == 0) ? rem_sn[k][i] : (rem_sn[k][i] << 1);
				take[i] = (cand[i] >= (LW+1)'(l_sn[k]));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k+1] <= 1'b0;
			end else if (en) begin
				vld_sn[k+1] <= vld_sn[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					rem_sn[k+1][i] <= take[i] ? cand[i] - (LW+1)'(l_sn[k]) : cand[i];
					q_sn[k+1][i]   <= {q_sn[k][i][QW-2:0], take[i]};
				end
				l_sn[k+1]    <= l_sn[k];
				side_sn[k+1] <= side_sn[k];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q[i]   = q_sn[QW][i];
			// round half away from zero: twice the remainder against the divisor
			rnd[i] = ((LW+2)'(rem_sn[QW][i]) << 1) >= (LW+2)'(l_sn[QW]);
		end
	end

	assign out_valid = vld_sn[QW];
	assign l_out     = l_sn[QW];
	assign side_out  = side_sn[QW];

endmodule

// ===== rtl/tpa_back.sv =====
// Back section: signed unit normal, area, dot product with the first vertex
// and the rounded, saturated plane offset. Four register stages; uses tpa_pkg.
module tpa_back import tpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [2:0][QW-1:0]   q,
	input  logic [2:0]           rnd,
	input  logic [LW-1:0]        l,
	input  tri_side_t            side,
	output logic                 out_valid,
	output tpa_res_t             res
);

	logic [4:1] vld_s;

	logic signed [NQ_W-1:0]   nq_s1   [3];
	coord_t                   a_s1    [3];
	logic [AREA_W-1:0]        area_s1;
	logic                     degen_s1;
	logic signed [DOT_PW-1:0] prod_s2 [3];
	logic signed [NQ_W-1:0]   nq_s2   [3];
	logic [AREA_W-1:0]        area_s2;
	logic                     degen_s2;
	logic signed [DOT_W-1:0]  dot_s3;
	logic signed [NQ_W-1:0]   nq_s3   [3];
	logic [AREA_W-1:0]        area_s3;
	logic                     degen_s3;
	tpa_res_t                 res_s4;

	logic [QW:0]              qr   [3];
	logic signed [NQ_W-1:0]   nq   [3];
	logic [LW:0]              lsum;
	logic [DOT_W-1:0]         dmag;
	logic [DOT_W:0]           rsum;
	logic [DOT_W-22:0]        dfull;
	logic [DM_W-1:0]          dm;
	logic signed [DM_W:0]     dsig;
	logic signed [D_W-1:0]    dsat;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qr[i] = (QW+1)'(q[i]) + (QW+1)'(rnd[i]);
			if (qr[i] > (QW+1)'(ONE_Q22)) begin
				qr[i] = (QW+1)'(ONE_Q22);
			end
			if (side.degen) begin
				nq[i] = '0;
			end else if (side.neg[i]) begin
				nq[i] = -$signed(NQ_W'(qr[i]));
			end else begin
				nq[i] = $signed(NQ_W'(qr[i]));
			end
		end
		lsum = (LW+1)'(l) + (LW+1)'(4096);

		dmag  = dot_s3[DOT_W-1] ? DOT_W'(-dot_s3) : DOT_W'(dot_s3);
		rsum  = (DOT_W+1)'(dmag) + ((DOT_W+1)'(1) << 21);
		dfull = rsum[DOT_W:22];
		dm    = (dfull > (DOT_W-21)'(DM_LIMIT)) ? DM_LIMIT : dfull[DM_W-1:0];
		// offset is minus the rounded dot product
		dsig  = dot_s3[DOT_W-1] ? $signed({1'b0, dm}) : -$signed({1'b0, dm});
		if (dsig > (DM_W+1)'(D_MAX)) begin
			dsat = D_MAX;
		end else if (dsig < (DM_W+1)'(D_MIN)) begin
			dsat = D_MIN;
		end else begin
			dsat = D_W'(dsig);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[3:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nq_s1[i]   <= nq[i];
				a_s1[i]    <= side.a[i];
				prod_s2[i] <= nq_s1[i] * a_s1[i];
				nq_s2[i]   <= nq_s1[i];
				nq_s3[i]   <= nq_s2[i];
			end
			area_s1  <= side.degen ? '0 : lsum[13 +: AREA_W];
			degen_s1 <= side.degen;
			area_s2  <= area_s1;
			degen_s2 <= degen_s1;
			dot_s3   <= DOT_W'(prod_s2[0]) + DOT_W'(prod_s2[1]) + DOT_W'(prod_s2[2]);
			area_s3  <= area_s2;
			degen_s3 <= degen_s2;
			res_s4.nx     <= nq_s3[0];
			res_s4.ny     <= nq_s3[1];
			res_s4.nz     <= nq_s3[2];
			res_s4.offset <= degen_s3 ? '0 : dsat;
			res_s4.area   <= area_s3;
			res_s4.degen  <= degen_s3;
		end
	end

	assign out_valid = vld_s[4];
	assign res       = res_s4;

endmodule

// ===== rtl/triangle_plane_and_area.sv =====
// Top level of the triangle plane and area pipeline: front, square root,
// dividers, back section and the output register with its skid stage.
// Depends on tpa_pkg, tpa_front, tpa_sqrt, tpa_div and tpa_back.
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  s_tdata: a, b, c vertices
//   m_*       out        m_tvalid/m_tready  m_tdata: normal, offset, area; m_tuser: degenerate
//
// One triangle enters per cycle while the skid stage is empty and passes
// through 6 front, 50 square root, 23 divide and 4 back stages and the
// output register. The depth is set by the one-bit-per-stage square root and divide.
// Reset clears only the valid bits and the output handshake state.
// A stall on m_tready fills the skid stage, then freezes the whole pipeline
// and drops s_tready; nothing is lost or repeated.
module triangle_plane_and_area import tpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 24 bits each from bit 0
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// normal_x, normal_y, normal_z (24 each), plane_offset (25), area (37), zero pad
	output logic [OUT_W-1:0] m_tdata,
	// degenerate
	output logic [0:0]       m_tuser
);

	logic              en;
	coord_t [2:0]      va, vb, vc;

	logic              fr_valid;
	logic [SW-1:0]     fr_s;
	mag_t [2:0]        fr_m;
	tri_side_t         fr_side;

	logic              sq_valid;
	logic [LW-1:0]     sq_l;
	mag_t [2:0]        sq_m;
	tri_side_t         sq_side;

	logic              dv_valid;
	logic [2:0][QW-1:0] dv_q;
	logic [2:0]        dv_rnd;
	logic [LW-1:0]     dv_l;
	tri_side_t         dv_side;

	logic              bk_valid;
	tpa_res_t          bk_res;

	logic              out_valid_q;
	logic              skid_valid_q;
	tpa_res_t          out_q;
	tpa_res_t          skid_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i] = s_tdata[CW*i +: CW];
			vb[i] = s_tdata[CW*(i+3) +: CW];
			vc[i] = s_tdata[CW*(i+6) +: CW];
		end
	end

	// the pipeline moves while the skid stage is empty
	assign en       = !skid_valid_q;
	assign s_tready = en;

	tpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.a         (va),
		.b         (vb),
		.c         (vc),
		.out_valid (fr_valid),
		.s         (fr_s),
		.m         (fr_m),
		.side      (fr_side)
	);

	tpa_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.s         (fr_s),
		.m         (fr_m),
		.side      (fr_side),
		.out_valid (sq_valid),
		.l         (sq_l),
		.m_out     (sq_m),
		.side_out  (sq_side)
	);

	tpa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.l         (sq_l),
		.m         (sq_m),
		.side      (sq_side),
		.out_valid (dv_valid),
		.q         (dv_q),
		.rnd       (dv_rnd),
		.l_out     (dv_l),
		.side_out  (dv_side)
	);

	tpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid),
		.q         (dv_q),
		.rnd       (dv_rnd),
		.l         (dv_l),
		.side      (dv_side),
		.out_valid (bk_valid),
		.res       (bk_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= bk_valid;
		end else if (bk_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || m_tready) begin
			out_q <= bk_res;
		end else begin
			// hold the pipeline word while the output waits
			skid_q <= bk_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.area, out_q.offset, out_q.nz, out_q.ny, out_q.nx};
	assign m_tuser  = out_q.degen;

endmodule

// ===== rtl/tpa_checker.sv =====
// Port-level checks for triangle_plane_and_area, attached by bind.
// Depends on tpa_pkg and the top level's ports.
module tpa_checker import tpa_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [0:0]       m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[133:0] == '0)
		else $error("degenerate triangle with nonzero fields");

	a_normal_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[71:0] != '0)
		else $error("zero normal on a proper triangle");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[23:0]) <= 24'sd4194304
			&& $signed(m_tdata[23:0]) >= -24'sd4194304
			&& $signed(m_tdata[47:24]) <= 24'sd4194304
			&& $signed(m_tdata[47:24]) >= -24'sd4194304
			&& $signed(m_tdata[71:48]) <= 24'sd4194304
			&& $signed(m_tdata[71:48]) >= -24'sd4194304)
		else $error("normal component beyond one");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no output waiting");

endmodule

bind triangle_plane_and_area tpa_checker u_tpa_checker (.*);

// ===== test/tb_top.sv =====
// Testbench for triangle_plane_and_area: drives triangles on the input stream,
// predicts normal, plane offset, area and degenerate flag, and checks each result.
// Depends on tpa_pkg and the triangle_plane_and_area RTL.
module tb_top;
	import tpa_pkg::*;

	typedef struct packed {
		logic signed [23:0] nx, ny, nz;
		logic signed [24:0] offset;
		logic [36:0]        area;
		logic               degen;
	} face_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [0:0]       m_tuser;

	face_t faces_due[$];
	int    errors;
	int    n_sent;
	int    n_checked;
	int    n_degen;
	int    idle_pct;
	int    stall_pct;

	triangle_plane_and_area i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("FAIL triangle_plane_and_area");
		$finish;
	end

	function automatic logic [63:0] isqrt(logic [101:0] s);
		logic [63:0]  r;
		logic [63:0]  c;
		r = 0;
		for (int b = 51; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= {26'd0, s})
				r = c;
		end
		return r;
	endfunction

	// round(m * 2^22 / l), ties away from zero, capped at one
	function automatic logic signed [63:0] unit_comp(logic signed [63:0] n, logic [63:0] l);
		logic [127:0] num;
		logic [127:0] q;
		logic [127:0] rem;
		logic [63:0]  m;
		m = n < 0 ? -n : n;
		num = {64'd0, m} << 22;
		q = num / l;
		rem = num % l;
		if (rem >= l - rem)
			q++;
		if (q > 128'd4194304)
			q = 128'd4194304;
		return n < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	function automatic face_t face_of(logic [IN_W-1:0] w);
		face_t f;
		logic signed [63:0]  v[9];
		logic signed [63:0]  e1[3], e2[3], n[3], nq[3];
		logic signed [127:0] dot;
		logic [127:0]        dm;
		logic [101:0]        s;
		logic [63:0]         l;
		logic signed [63:0]  d;
		for (int i = 0; i < 9; i++)
			v[i] = $signed(w[i*24 +: 24]);
		for (int i = 0; i < 3; i++) begin
			e1[i] = v[3+i] - v[i];
			e2[i] = v[6+i] - v[i];
		end
		n[0] = e1[1] * e2[2] - e1[2] * e2[1];
		n[1] = e1[2] * e2[0] - e1[0] * e2[2];
		n[2] = e1[0] * e2[1] - e1[1] * e2[0];
		s = 0;
		for (int i = 0; i < 3; i++)
			s += 102'($signed(128'(n[i])) * $signed(128'(n[i])));
		f = '{default: '0};
		if (s == 0) begin
			f.degen = 1'b1;
			return f;
		end
		l = isqrt(s);
		for (int i = 0; i < 3; i++)
			nq[i] = unit_comp(n[i], l);
		dot = 128'(nq[0]) * 128'(v[0]) + 128'(nq[1]) * 128'(v[1]) + 128'(nq[2]) * 128'(v[2]);
		dm = ((dot < 0 ? -dot : dot) + (128'd1 << 21)) >> 22;
		if (dm > (128'd1 << 26))
			dm = 128'd1 << 26;
		d = dot < 0 ? 64'(dm) : -64'(dm);
		if (d > 64'sd16777215)
			d = 64'sd16777215;
		if (d < -64'sd16777216)
			d = -64'sd16777216;
		f.nx = nq[0][23:0];
		f.ny = nq[1][23:0];
		f.nz = nq[2][23:0];
		f.offset = d[24:0];
		f.area = 37'((l + 64'd4096) >> 13);
		return f;
	endfunction

	task automatic send_tri(logic [IN_W-1:0] w);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata  <= w;
		s_tvalid <= 1'b1;
		faces_due.push_back(face_of(w));
		do @(posedge clk); while (!s_tready);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic send_pts(int ax, int ay, int az, int bx, int by, int bz,
			int cx, int cy, int cz);
		send_tri({24'(cz), 24'(cy), 24'(cx), 24'(bz), 24'(by), 24'(bx),
			24'(az), 24'(ay), 24'(ax)});
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (faces_due.size() != 0)
			@(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		face_t e;
		face_t g;
		if (arst_n && m_tvalid && m_tready) begin
			g.nx = m_tdata[23:0];
			g.ny = m_tdata[47:24];
			g.nz = m_tdata[71:48];
			g.offset = m_tdata[96:72];
			g.area = m_tdata[133:97];
			g.degen = m_tuser[0];
			n_checked++;
			if (faces_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word %h", m_tdata);
			end else begin
				e = faces_due.pop_front();
				if (e.degen)
					n_degen++;
				if (g != e) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch: exp n=(%0d,%0d,%0d) d=%0d a=%0d g=%0d",
							e.nx, e.ny, e.nz, e.offset, e.area, e.degen);
						$display("          got n=(%0d,%0d,%0d) d=%0d a=%0d g=%0d",
							g.nx, g.ny, g.nz, g.offset, g.area, g.degen);
					end
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	task automatic test_directed();
		int mx;
		int mn;
		mx = 8388607;
		mn = -8388608;
		send_pts(0, 0, 0, 4096, 0, 0, 0, 4096, 0);
		send_pts(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_pts(1, 2, 3, 2, 4, 6, 3, 6, 9);
		send_pts(5, 5, 5, 5, 5, 5, 9, 1, 7);
		send_pts(0, 0, 0, 1, 0, 0, 0, 1, 0);
		send_pts(mn, mn, mn, mx, mn, mn, mn, mx, mn);
		send_pts(mx, mx, mx, mn, mx, mx, mx, mn, mx);
		send_pts(mn, mn, mn, mx, mx, mx, mn, mx, mn);
		send_pts(mx, mn, mx, mn, mx, mn, mx, mx, mn);
		send_pts(mx, mx, mx, mn, mn, mn, mx, mn, mn);
		send_pts(mn, mx, mn, mx, mn, mx, mn, mn, mx);
		send_pts(mx, 0, 0, 0, mx, 0, 0, 0, mx);
		send_pts(mn, 0, 0, 0, mn, 0, 0, 0, mn);
		send_pts(mx, mx, mx, mx, mx, mn, mx, mn, mx);
		send_pts(-1, -1, -1, 0, -1, -1, -1, 0, -1);
		send_pts(100, 200, 300, 100, 200, 300, 100, 200, 301);
		send_pts(0, 0, mx, 4096, 0, mx, 0, 4096, mx);
		send_pts(0, 0, mn, 0, 4096, mn, 4096, 0, mn);
		send_pts(1, 1, 1, 2, 1, 1, 1, 1, 2);
		send_pts(mn, mx, 0, mx, mx, 0, mn, mn, 0);
		// wait out the pipeline before going on
		drain();
	endtask

	task automatic test_random(int count);
		logic [IN_W-1:0] w;
		int k;
		for (int i = 0; i < count; i++) begin
			for (int j = 0; j < 9; j++)
				w[j*24 +: 24] = 24'($urandom);
			k = $urandom_range(9);
			if (k == 0) begin
				// collinear: c on the line through a and b
				for (int j = 0; j < 3; j++)
					w[(6+j)*24 +: 24] = 24'(2 * w[(3+j)*24 +: 24] - w[j*24 +: 24]);
			end else if (k == 1) begin
				// small triangle near a random anchor
				for (int j = 3; j < 9; j++)
					w[j*24 +: 24] = w[(j%3)*24 +: 24] + 24'($urandom_range(8) - 4);
			end else if (k == 2) begin
				for (int j = 0; j < 9; j++)
					w[j*24 +: 24] = 24'($signed($urandom_range(65536)) - 32768);
			end
			send_tri(w);
		end
	endtask

	initial begin
		int phase_idle[4];
		int phase_stall[4];
		phase_idle = '{0, 61, 0, 35};
		phase_stall = '{0, 0, 61, 35};
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_degen = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			test_random(260);
		end
		stall_pct = 0;
		drain();
		repeat (200) @(negedge clk);
		$display("sent %0d triangles, checked %0d results (%0d degenerate)",
			n_sent, n_checked, n_degen);
		$display("directed extremes and random faces under idle and stall mixes");
		if (errors == 0 && faces_due.size() == 0)
			$display("PASS triangle_plane_and_area");
		else
			$display("FAIL triangle_plane_and_area");
		$finish;
	end
endmodule
